FILE: sv/ssi_pkg.sv
`default_nettype none

package ssi_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 16;

    localparam logic [INDEX_W-1:0] MATCH_MAX = {INDEX_W{1'b1}};

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PROBE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_en;
        logic probe_start;
        logic rd_en;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ref_empty;
        logic eq;
        logic gt;
        logic last;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

FILE: sv/ssi_intf.sv
`default_nettype none

interface ssi_item_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic signed [ssi_pkg::VALUE_W-1:0] value;
    logic                               starts_new_set;

    modport source (output valid, output cmd, output value, output starts_new_set,
                    input ready);
    modport sink   (input valid, input cmd, input value, input starts_new_set,
                    output ready);
endinterface

interface ssi_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [ssi_pkg::VALUE_W-1:0] match_value;
    logic        [ssi_pkg::INDEX_W-1:0] match_index;

    modport source (output valid, output match_value, output match_index, input ready);
    modport sink   (input valid, input match_value, input match_index, output ready);
endinterface

`default_nettype wire

FILE: sv/ssi_ctrl.sv
`default_nettype none

module ssi_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_cmd,
    output logic                       in_ready,
    input  wire ssi_pkg::ctrl_status_t status,
    output ssi_pkg::ctrl_cmd_t         ctrl
);

    ssi_pkg::state_t state_reg;
    ssi_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        ctrl.load_en     = 1'b0;
        ctrl.probe_start = 1'b0;
        ctrl.rd_en       = 1'b0;
        ctrl.emit        = 1'b0;
        unique case (state_reg)
            ssi_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == ssi_pkg::CMD_PROBE)
                    begin
                        ctrl.probe_start = 1'b1;
                        if (!status.ref_empty)
                        begin
                            state_next = ssi_pkg::ST_FETCH;
                        end
                    end
                    else
                    begin
                        ctrl.load_en = 1'b1;
                    end
                end
            end
            ssi_pkg::ST_FETCH:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ssi_pkg::ST_SCAN;
            end
            ssi_pkg::ST_SCAN:
            begin
                if (status.eq)
                begin
                    state_next = ssi_pkg::ST_EMIT;
                end
                else if (status.gt || status.last)
                begin
                    state_next = ssi_pkg::ST_IDLE;
                end
                else
                begin
                    ctrl.rd_en = 1'b1;
                end
            end
            ssi_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = ssi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/ssi_datapath.sv
`default_nettype none

module ssi_datapath #(
    parameter int SET_DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [ssi_pkg::VALUE_W-1:0] in_value,
    input  wire logic                               in_start,
    input  wire ssi_pkg::ctrl_cmd_t                 ctrl,
    output ssi_pkg::ctrl_status_t                   status,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic signed [ssi_pkg::VALUE_W-1:0]      match_value,
    output logic        [ssi_pkg::INDEX_W-1:0]      match_index
);

    localparam int IDX_W = $clog2(SET_DEPTH);
    localparam int CNT_W = $clog2(SET_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);

    logic signed [ssi_pkg::VALUE_W-1:0] mem [SET_DEPTH];

    logic        [CNT_W-1:0]            ref_count_reg;
    logic        [CNT_W-1:0]            addr_reg;
    logic        [ssi_pkg::INDEX_W-1:0] match_count_reg;
    logic signed [ssi_pkg::VALUE_W-1:0] probe_reg;
    logic signed [ssi_pkg::VALUE_W-1:0] rd_data_reg;
    logic                               out_valid_reg;
    logic signed [ssi_pkg::VALUE_W-1:0] match_value_reg;
    logic        [ssi_pkg::INDEX_W-1:0] match_index_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // a start flag rewinds the set to entry 0; a full set drops the load
    assign wr_en   = ctrl.load_en && (in_start || (ref_count_reg < DEPTH_C));
    assign wr_addr = in_start ? '0 : ref_count_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.probe_start)
        begin
            probe_reg <= in_value;
        end
        if (ctrl.emit)
        begin
            match_value_reg <= probe_reg;
            match_index_reg <= match_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg   <= '0;
            addr_reg        <= '0;
            match_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                ref_count_reg <= in_start ? CNT_W'(1) : ref_count_reg + CNT_W'(1);
            end
            if (ctrl.probe_start)
            begin
                addr_reg <= '0;
            end
            else if (ctrl.rd_en)
            begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            if (ctrl.probe_start && in_start)
            begin
                match_count_reg <= '0;
            end
            else if (ctrl.emit && (match_count_reg != ssi_pkg::MATCH_MAX))
            begin
                match_count_reg <= match_count_reg + ssi_pkg::INDEX_W'(1);
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // rd_data_reg holds the entry at addr_reg - 1 while scanning
    assign status.ref_empty = (ref_count_reg == '0);
    assign status.eq        = (rd_data_reg == probe_reg);
    assign status.gt        = (rd_data_reg > probe_reg);
    assign status.last      = (addr_reg == ref_count_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign match_value = match_value_reg;
    assign match_index = match_index_reg;

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // only written entries are read
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rd_en |-> (addr_reg < ref_count_reg))
        else $error("read beyond stored set");

    // emitted value equals the entry that matched
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (rd_data_reg == probe_reg))
        else $error("emit without equal entry");

    // saturated match count stays saturated until a new start
    assert property (@(posedge clk) disable iff (!rst_n)
        (match_count_reg == ssi_pkg::MATCH_MAX) && !ctrl.probe_start
        |=> (match_count_reg == ssi_pkg::MATCH_MAX))
        else $error("match count left saturation");

endmodule

`default_nettype wire

FILE: sv/sorted_set_intersection_core.sv
// channel  dir  modport  payload
// item     in   sink     cmd (0 load, 1 probe), value (s32), starts_new_set
// result   out  source   match_value (s32), match_index (u16, saturating)
//
// a load writes its value into the set memory; a probe scans the stored entries
// in order until an equal, a greater or the last entry, and emits on a match;
// the set memory gives one entry a cycle through its single registered read port
// reset clears the set count and match count; the memory needs no clearing pass
// results sit in a one-deep output register; the next item is accepted while
// it waits, and a later match holds in the emit state until it is taken
`default_nettype none

module sorted_set_intersection_core #(
    parameter int SET_DEPTH = 256
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ssi_item_if.sink   item,
    ssi_result_if.source result
);

    ssi_pkg::ctrl_cmd_t    ctrl;
    ssi_pkg::ctrl_status_t status;

    // sequencer: accepts items, walks the scan, hands off matches
    ssi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_cmd   (item.cmd),
        .in_ready (item.ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // set memory, counters, comparator and output register
    ssi_datapath #(
        .SET_DEPTH (SET_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_value    (item.value),
        .in_start    (item.starts_new_set),
        .ctrl        (ctrl),
        .status      (status),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .match_value (result.match_value),
        .match_index (result.match_index)
    );

endmodule

`default_nettype wire
